### rtl/tlnf_pkg.sv
// Shared types, constants and the byte rendering function of the line-number filter.
package tlnf_pkg;

    // Default count of decimal places in the line number
    localparam int NUMBER_DIGITS_DEF = 6;

    // Configuration port geometry
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    // Register indexes on the configuration port
    typedef enum logic [REG_IDX_W-1:0] {
        REG_NUMBER_NONBLANK  = 3'd0,
        REG_NUMBER_ALL       = 3'd1,
        REG_SQUEEZE_BLANK    = 3'd2,
        REG_SHOW_NONPRINTING = 3'd3,
        REG_SHOW_TABS        = 3'd4,
        REG_SHOW_ENDS        = 3'd5
    } reg_idx_t;

    // Character codes
    localparam logic [7:0] CH_TAB      = 8'd9;
    localparam logic [7:0] CH_LF       = 8'd10;
    localparam logic [7:0] CH_SPACE    = 8'd32;
    localparam logic [7:0] CH_DOLLAR   = 8'd36;
    localparam logic [7:0] CH_MINUS    = 8'd45;
    localparam logic [7:0] CH_ZERO     = 8'd48;
    localparam logic [7:0] CH_QUEST    = 8'd63;
    localparam logic [7:0] CH_CAP_I    = 8'd73;
    localparam logic [7:0] CH_CAP_M    = 8'd77;
    localparam logic [7:0] CH_CARET    = 8'd94;
    localparam logic [7:0] CH_PRINT_LO = 8'd32;
    localparam logic [7:0] CH_PRINT_HI = 8'd126;
    localparam logic [7:0] CH_DEL      = 8'd127;
    localparam logic [7:0] CH_HIGH_BIT = 8'd128;
    localparam logic [7:0] CH_META_PRN = 8'd160;
    localparam logic [7:0] CH_META_DEL = 8'd255;
    localparam logic [7:0] CARET_OFS   = 8'd64;

    // Bytes a single input byte renders to, at most four
    localparam int RENDER_MAX = 4;

    typedef struct packed {
        logic number_nonblank;
        logic number_all;
        logic squeeze_blank;
        logic show_nonprinting;
        logic show_tabs;
        logic show_ends;
    } cfg_t;

    typedef struct packed {
        logic [RENDER_MAX-1:0][7:0] bytes;
        logic [2:0]                 count;
    } render_t;

    // Visible form of one byte: $ before LF, ^I for tab, caret and M- notation
    function automatic render_t render_byte(input logic [7:0] c, input cfg_t cfg);
        render_t r;
        r.bytes    = '0;
        r.bytes[0] = c;
        r.count    = 3'd1;
        if (c == CH_LF && cfg.show_ends) begin
            r.bytes[0] = CH_DOLLAR;
            r.bytes[1] = CH_LF;
            r.count    = 3'd2;
        end else if (c == CH_TAB && cfg.show_tabs) begin
            r.bytes[0] = CH_CARET;
            r.bytes[1] = CH_CAP_I;
            r.count    = 3'd2;
        end else if (cfg.show_nonprinting && c != CH_LF && c != CH_TAB) begin
            if (c >= CH_PRINT_LO && c <= CH_PRINT_HI) begin
                r.count = 3'd1;
            end else if (c < CH_PRINT_LO || c == CH_DEL) begin
                r.bytes[0] = CH_CARET;
                r.bytes[1] = (c == CH_DEL) ? CH_QUEST : c + CARET_OFS;
                r.count    = 3'd2;
            end else begin
                r.bytes[0] = CH_CAP_M;
                r.bytes[1] = CH_MINUS;
                if (c >= CH_META_PRN) begin
                    if (c != CH_META_DEL) begin
                        r.bytes[2] = c - CH_HIGH_BIT;
                        r.count    = 3'd3;
                    end else begin
                        r.bytes[2] = CH_CARET;
                        r.bytes[3] = CH_QUEST;
                        r.count    = 3'd4;
                    end
                end else begin
                    // high control byte: strip bit 7, then caret form
                    r.bytes[2] = CH_CARET;
                    r.bytes[3] = c - CH_HIGH_BIT + CARET_OFS;
                    r.count    = 3'd4;
                end
            end
        end
        return r;
    endfunction

endpackage

### rtl/tlnf_regs.sv
// APB configuration registers of the line-number filter.
module tlnf_regs
    import tlnf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t           cfg_reg;
    cfg_t           cfg_next;
    logic           wr_en;
    reg_idx_t       idx;
    logic           rd_bit;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
    assign cfg    = cfg_reg;

    // Register write decode; indexes past the list are ignored
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_NUMBER_NONBLANK:  cfg_next.number_nonblank  = pwdata[0];
                REG_NUMBER_ALL:       cfg_next.number_all       = pwdata[0];
                REG_SQUEEZE_BLANK:    cfg_next.squeeze_blank    = pwdata[0];
                REG_SHOW_NONPRINTING: cfg_next.show_nonprinting = pwdata[0];
                REG_SHOW_TABS:        cfg_next.show_tabs        = pwdata[0];
                REG_SHOW_ENDS:        cfg_next.show_ends        = pwdata[0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (idx)
            REG_NUMBER_NONBLANK:  rd_bit = cfg_reg.number_nonblank;
            REG_NUMBER_ALL:       rd_bit = cfg_reg.number_all;
            REG_SQUEEZE_BLANK:    rd_bit = cfg_reg.squeeze_blank;
            REG_SHOW_NONPRINTING: rd_bit = cfg_reg.show_nonprinting;
            REG_SHOW_TABS:        rd_bit = cfg_reg.show_tabs;
            REG_SHOW_ENDS:        rd_bit = cfg_reg.show_ends;
            default:              rd_bit = 1'b0;
        endcase
    end

    assign prdata = {{(CFG_DATA_W-1){1'b0}}, rd_bit};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### rtl/tlnf_front.sv
// Line state and per-byte decode: builds the output byte run for one input transaction.
module tlnf_front
    import tlnf_pkg::*;
#(
    parameter int NUMBER_DIGITS = NUMBER_DIGITS_DEF,
    localparam int SLOTS = NUMBER_DIGITS + 1 + RENDER_MAX,
    localparam int CNT_W = $clog2(SLOTS + 1),
    localparam int LN_W  = 4 * NUMBER_DIGITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cfg_t                  cfg,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_data_byte,
    output logic                  run_valid,
    input  logic                  run_ready,
    output logic [SLOTS-1:0][7:0] run_bytes,
    output logic [CNT_W-1:0]      run_count
);

    logic [7:0]      prev_reg,  prev_next;
    logic [1:0]      blank_reg, blank_next;
    logic [LN_W-1:0] ln_reg,    ln_next;

    logic            accept;
    logic            line_start;
    logic            is_lf;
    logic            num_en;
    logic            render_en;
    render_t         rend;
    logic [NUMBER_DIGITS-1:0][7:0] digit_ch;
    logic [LN_W-1:0] ln_inc;
    logic [CNT_W-1:0] num_part;
    logic [CNT_W-1:0] rend_part;

    assign s_ready    = run_ready;
    assign accept     = s_valid && s_ready;
    assign line_start = (prev_reg == CH_LF);
    assign is_lf      = (s_data_byte == CH_LF);

    // Blank-line run counter, saturating at three
    always_comb begin
        if (line_start && is_lf && cfg.squeeze_blank) begin
            blank_next = (blank_reg == 2'd3) ? 2'd3 : blank_reg + 2'd1;
        end else begin
            blank_next = 2'd0;
        end
    end

    assign render_en = (blank_next < 2'd2);

    // Number decision at the start of a line
    always_comb begin
        num_en = 1'b0;
        if (line_start) begin
            if (cfg.number_nonblank) begin
                num_en = !is_lf;
            end else begin
                num_en = cfg.number_all && render_en;
            end
        end
    end

    // Line number digits, most significant first, leading zeros as spaces
    always_comb begin
        logic       lead;
        logic [3:0] d;
        lead = 1'b1;
        for (int k = 0; k < NUMBER_DIGITS; k++) begin
            d = ln_reg[(NUMBER_DIGITS-1-k)*4 +: 4];
            if (d != 4'd0 || k == NUMBER_DIGITS-1) begin
                lead = 1'b0;
            end
            digit_ch[k] = lead ? CH_SPACE : CH_ZERO + {4'd0, d};
        end
    end

    // BCD increment that holds at all nines
    always_comb begin
        logic carry;
        logic all_nines;
        logic [3:0] d;
        all_nines = 1'b1;
        carry     = 1'b1;
        ln_inc    = ln_reg;
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
            if (ln_reg[i*4 +: 4] != 4'd9) begin
                all_nines = 1'b0;
            end
        end
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
            d = ln_reg[i*4 +: 4];
            if (carry) begin
                if (d == 4'd9) begin
                    ln_inc[i*4 +: 4] = 4'd0;
                end else begin
                    ln_inc[i*4 +: 4] = d + 4'd1;
                    carry = 1'b0;
                end
            end
        end
        if (all_nines) begin
            ln_inc = ln_reg;
        end
    end

    assign rend = render_byte(s_data_byte, cfg);

    // Pack the run: number and tab first when numbered, then the rendered bytes
    always_comb begin
        run_bytes = '0;
        if (num_en) begin
            for (int k = 0; k < NUMBER_DIGITS; k++) begin
                run_bytes[k] = digit_ch[k];
            end
            run_bytes[NUMBER_DIGITS] = CH_TAB;
            for (int j = 0; j < RENDER_MAX; j++) begin
                run_bytes[NUMBER_DIGITS+1+j] = rend.bytes[j];
            end
        end else begin
            for (int j = 0; j < RENDER_MAX; j++) begin
                run_bytes[j] = rend.bytes[j];
            end
        end
    end

    assign num_part  = num_en ? CNT_W'(NUMBER_DIGITS + 1) : '0;
    assign rend_part = render_en ? CNT_W'(rend.count) : '0;
    assign run_count = num_part + rend_part;
    assign run_valid = s_valid && (run_count != '0);

    // State update on every accepted transaction
    always_comb begin
        prev_next  = prev_reg;
        ln_next    = ln_reg;
        if (accept) begin
            prev_next = s_data_byte;
            if (num_en) begin
                ln_next = ln_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg  <= CH_LF;
            blank_reg <= 2'd0;
            ln_reg    <= LN_W'(1);
        end else begin
            prev_reg <= prev_next;
            ln_reg   <= ln_next;
            if (accept) begin
                blank_reg <= blank_next;
            end
        end
    end

endmodule

### rtl/tlnf_emit.sv
// Run register and output register: sends the bytes of one run, one per cycle while m_ready does not stall it.
module tlnf_emit
    import tlnf_pkg::*;
#(
    parameter int NUMBER_DIGITS = NUMBER_DIGITS_DEF,
    localparam int SLOTS = NUMBER_DIGITS + 1 + RENDER_MAX,
    localparam int CNT_W = $clog2(SLOTS + 1),
    localparam int IDX_W = $clog2(SLOTS)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  run_valid,
    output logic                  run_ready,
    input  logic [SLOTS-1:0][7:0] run_bytes,
    input  logic [CNT_W-1:0]      run_count,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_out_byte,
    output logic                  m_last_of_run
);

    logic                  busy_reg;
    logic [SLOTS-1:0][7:0] bytes_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic                  m_valid_reg;
    logic [7:0]            m_byte_reg;
    logic                  m_last_reg;

    logic out_free;
    logic advance;
    logic at_last;
    logic load;

    assign out_free  = !m_valid_reg || m_ready;
    assign advance   = busy_reg && out_free;
    assign at_last   = (CNT_W'(idx_reg) == count_reg - CNT_W'(1));
    assign run_ready = !busy_reg || (advance && at_last);
    assign load      = run_valid && run_ready;

    // Run register and byte index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            if (load) begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end else if (advance && at_last) begin
                busy_reg <= 1'b0;
            end else if (advance) begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            bytes_reg <= run_bytes;
            count_reg <= run_count;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_byte_reg <= bytes_reg[idx_reg];
            m_last_reg <= at_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = m_byte_reg;
    assign m_last_of_run = m_last_reg;

endmodule

### rtl/text_line_number_visible_filter.sv
// Top level of the text filter: line numbering, blank squeezing and visible rendering.
// Takes one text byte per input transaction and sends zero or more rendered bytes, the last
// one flagged by m_last_of_run. A byte is decoded in the cycle it is accepted and lands in
// a run register; the output register then sends the run one byte per cycle while m_ready
// is high. A byte that renders to one output byte thus sustains one transaction per cycle
// without stalls; a byte that yields more (up to NUMBER_DIGITS + 5 with a line number and
// M-^X form) holds s_ready low until its last byte enters the output register. A squeezed
// blank line with no number produces no output transaction at all. Configuration registers
// sit at byte addresses 0, 4, ... 20; the user writes them only while idle (not enforced).
module text_line_number_visible_filter
    import tlnf_pkg::*;
#(
    parameter int NUMBER_DIGITS = NUMBER_DIGITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_data_byte,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_out_byte,
    output logic                  m_last_of_run
);

    localparam int SLOTS = NUMBER_DIGITS + 1 + RENDER_MAX;
    localparam int CNT_W = $clog2(SLOTS + 1);

    cfg_t                  cfg;
    logic                  run_valid;
    logic                  run_ready;
    logic [SLOTS-1:0][7:0] run_bytes;
    logic [CNT_W-1:0]      run_count;

    tlnf_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tlnf_front #(
        .NUMBER_DIGITS (NUMBER_DIGITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .run_valid   (run_valid),
        .run_ready   (run_ready),
        .run_bytes   (run_bytes),
        .run_count   (run_count)
    );

    tlnf_emit #(
        .NUMBER_DIGITS (NUMBER_DIGITS)
    ) u_emit (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .run_valid     (run_valid),
        .run_ready     (run_ready),
        .run_bytes     (run_bytes),
        .run_count     (run_count),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last_of_run (m_last_of_run)
    );

endmodule

### rtl/tlnf_checker.sv
// Port-level checks of the line-number filter, bound to the top level.
module tlnf_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       pready,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic       m_last_of_run
);

    // A stalled output transaction holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_last_of_run))
        else $error("output transaction changed while stalled");

    // Input backpressure only while a run is pending, so output is valid next cycle
    a_stall_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |=> m_valid)
        else $error("input stalled without output activity");

    // Reset empties the output register
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    // Configuration port never inserts wait states
    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready low");

endmodule

bind text_line_number_visible_filter tlnf_checker u_tlnf_checker (.*);

### verif/text_line_number_visible_filter_tb.sv
// Self-checking testbench for the line-number / visible-character text filter.
module text_line_number_visible_filter_tb;
    import tlnf_pkg::*;

    localparam int NUM_DIGITS    = NUMBER_DIGITS_DEF;
    localparam int PHASE_ITEMS   = 32;
    localparam int RANDOM_PHASES = 9;
    localparam int DRAIN_CYCLES  = 24;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DIRECTED_LEN  = 15;

    // Register indexes with no register behind them
    localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } rendered_char_t;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr         = '0;
    logic [CFG_DATA_W-1:0] pwdata        = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic [7:0]            s_data_byte   = '0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic [7:0]            m_out_byte;
    logic                  m_last_of_run;

    // Filter state as seen by the predictor
    cfg_t                    filter_cfg     = '0;
    logic [7:0]              prev_text_byte = CH_LF;
    logic [1:0]              blank_lines    = 2'd0;
    logic [4*NUM_DIGITS-1:0] line_count_bcd = (4*NUM_DIGITS)'(1);

    logic [7:0]     text_bytes[$];
    logic [7:0]     run_chars[$];
    rendered_char_t expected_chars[$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int stall_pct      = 0;
    int send_gap       = 0;
    int stall_left     = 0;

    text_line_number_visible_filter DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last_of_run (m_last_of_run)
    );

    // Clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic void append_char(input logic [7:0] c);
        run_chars.push_back(c);
    endfunction

    // Right-aligned number plus tab, then bump the BCD count (sticks at all nines)
    function automatic void append_line_number();
        logic [3:0] digit;
        logic       leading;
        logic       all_nines;
        leading   = 1'b1;
        all_nines = 1'b1;
        for (int i = NUM_DIGITS - 1; i >= 0; i--) begin
            digit = line_count_bcd[4*i +: 4];
            if (digit > 4'd9)
                digit = 4'd9;
            if (digit != 4'd0 || i == 0)
                leading = 1'b0;
            append_char(leading ? CH_SPACE : CH_ZERO + {4'd0, digit});
        end
        append_char(CH_TAB);
        for (int i = 0; i < NUM_DIGITS; i++)
            if (line_count_bcd[4*i +: 4] != 4'd9)
                all_nines = 1'b0;
        if (!all_nines) begin
            for (int i = 0; i < NUM_DIGITS; i++) begin
                if (line_count_bcd[4*i +: 4] >= 4'd9) begin
                    line_count_bcd[4*i +: 4] = 4'd0;
                end else begin
                    line_count_bcd[4*i +: 4] = line_count_bcd[4*i +: 4] + 4'd1;
                    break;
                end
            end
        end
    endfunction

    // Visible form of one text byte
    function automatic void append_rendered(input logic [7:0] c);
        if (c == CH_LF && filter_cfg.show_ends) begin
            append_char(CH_DOLLAR);
            append_char(CH_LF);
        end else if (c == CH_TAB && filter_cfg.show_tabs) begin
            append_char(CH_CARET);
            append_char(CH_CAP_I);
        end else if (filter_cfg.show_nonprinting && c != CH_LF && c != CH_TAB) begin
            if (c >= CH_PRINT_LO && c <= CH_PRINT_HI) begin
                append_char(c);
            end else if (c < CH_PRINT_LO || c == CH_DEL) begin
                append_char(CH_CARET);
                append_char(c == CH_DEL ? CH_QUEST : c + CARET_OFS);
            end else begin
                append_char(CH_CAP_M);
                append_char(CH_MINUS);
                if (c == CH_META_DEL) begin
                    append_char(CH_CARET);
                    append_char(CH_QUEST);
                end else if (c >= CH_META_PRN) begin
                    append_char(c - CH_HIGH_BIT);
                end else begin
                    append_char(CH_CARET);
                    append_char(c - CH_HIGH_BIT + CARET_OFS);
                end
            end
        end else begin
            append_char(c);
        end
    endfunction

    // Everything one accepted byte should produce, queued in order
    function automatic void predict_run(input logic [7:0] b);
        logic line_start;
        line_start = (prev_text_byte == CH_LF);
        run_chars.delete();
        if (line_start && b == CH_LF && filter_cfg.squeeze_blank) begin
            if (blank_lines != 2'd3)
                blank_lines = blank_lines + 2'd1;
        end else begin
            blank_lines = 2'd0;
        end
        if (line_start) begin
            if (filter_cfg.number_nonblank) begin
                if (b != CH_LF)
                    append_line_number();
            end else if (filter_cfg.number_all && blank_lines < 2'd2) begin
                append_line_number();
            end
        end
        if (blank_lines < 2'd2)
            append_rendered(b);
        prev_text_byte = b;
        foreach (run_chars[i])
            expected_chars.push_back('{run_chars[i], i == run_chars.size() - 1});
    endfunction

    // ---------------------------------------------------------------
    // Input driver
    // ---------------------------------------------------------------
    always @(posedge aclk) begin : drive_bytes
        logic       next_valid;
        logic [7:0] next_byte;
        next_valid = s_valid;
        next_byte  = s_data_byte;
        if (!aresetn) begin
            next_valid = 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_run(s_data_byte);
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (text_bytes.size() != 0) begin
                    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
                        // idle gap, this one included, extended by send_gap
                        send_gap = $urandom_range(0, 6);
                    end else begin
                        next_valid = 1'b1;
                        next_byte  = text_bytes.pop_front();
                    end
                end
            end
        end
        s_valid     <= next_valid;
        s_data_byte <= next_byte;
    end

    // ---------------------------------------------------------------
    // Output monitor and backpressure
    // ---------------------------------------------------------------
    always @(posedge aclk) begin : check_output
        rendered_char_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %02h last %0b",
                                          m_out_byte, m_last_of_run));
            end else begin
                want = expected_chars.pop_front();
                if (m_out_byte !== want.out_byte || m_last_of_run !== want.last_of_run)
                    report_mismatch($sformatf("byte %02h last %0b, want %02h last %0b",
                                              m_out_byte, m_last_of_run,
                                              want.out_byte, want.last_of_run));
            end
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(0, 6);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Configuration port
    // ---------------------------------------------------------------
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_NUMBER_NONBLANK:  filter_cfg.number_nonblank  = value[0];
            REG_NUMBER_ALL:       filter_cfg.number_all       = value[0];
            REG_SQUEEZE_BLANK:    filter_cfg.squeeze_blank    = value[0];
            REG_SHOW_NONPRINTING: filter_cfg.show_nonprinting = value[0];
            REG_SHOW_TABS:        filter_cfg.show_tabs        = value[0];
            REG_SHOW_ENDS:        filter_cfg.show_ends        = value[0];
            default: ;
        endcase
    endtask

    task automatic read_reg(input logic [REG_IDX_W-1:0] idx, input logic want);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== {31'd0, want})
            report_mismatch($sformatf("register %0d reads %08h, want %0b", idx, prdata, want));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write all six registers (junk in the upper bits), then read them back
    task automatic load_filter_cfg(input cfg_t c);
        logic [5:0] bits;
        bits = c;
        for (int i = 0; i < 6; i++)
            write_reg(REG_IDX_W'(i), {$urandom() & 32'hFFFF_FFFE} | bits[5-i]);
        for (int i = 0; i < 6; i++)
            read_reg(REG_IDX_W'(i), bits[5-i]);
    endtask

    // Wait for the block to go quiet, then allow for a trailing squeezed line
    task automatic wait_drained();
        do
            @(negedge aclk);
        while (text_bytes.size() != 0 || s_valid || expected_chars.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Mostly text: printable runs and lines, with tabs, control and high bytes
    function automatic logic [7:0] random_text_byte();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)      return 8'($urandom_range(32, 126));
        else if (pick < 65) return CH_LF;
        else if (pick < 72) return CH_TAB;
        else if (pick < 82) return 8'($urandom_range(0, 31));
        else if (pick < 86) return CH_DEL;
        else                return 8'($urandom_range(128, 255));
    endfunction

    // ---------------------------------------------------------------
    // Stimulus sequence
    // ---------------------------------------------------------------
    initial begin : run_phases
        cfg_t       c;
        logic [7:0] directed[DIRECTED_LEN];
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Everything on but number_nonblank: numbers, squeezing, and every visible form
        c = '1;
        c.number_nonblank = 1'b0;
        send_idle_pct = 20;
        stall_pct     = 20;
        load_filter_cfg(c);
        directed = '{8'h41, CH_TAB, CH_LF, CH_LF, CH_LF, CH_LF, 8'h00, 8'h1F, CH_DEL,
                     8'h80, 8'h9F, 8'hA0, 8'hFE, 8'hFF, CH_LF};
        foreach (directed[i])
            text_bytes.push_back(directed[i]);
        wait_drained();

        // Nonblank numbering over number_all; raw tab and newline with only caret form
        c = '0;
        c.number_nonblank  = 1'b1;
        c.number_all       = 1'b1;
        c.squeeze_blank    = 1'b1;
        c.show_nonprinting = 1'b1;
        load_filter_cfg(c);
        text_bytes.push_back(CH_LF);
        text_bytes.push_back(CH_LF);
        text_bytes.push_back(CH_LF);
        text_bytes.push_back(CH_TAB);
        text_bytes.push_back(CH_LF);
        text_bytes.push_back(8'h7A);
        wait_drained();

        // Random phases: all off, all on, then random settings; last one runs flat out
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == 0)      c = '0;
            else if (phase == 1) c = '1;
            else                 c = cfg_t'(6'($urandom_range(0, 63)));
            case (phase % 3)
                0: begin send_idle_pct = 0;  stall_pct = 30; end
                1: begin send_idle_pct = 30; stall_pct = 0;  end
                default: begin send_idle_pct = 15; stall_pct = 15; end
            endcase
            if (phase == RANDOM_PHASES - 1) begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            load_filter_cfg(c);
            if (phase == 2) begin
                // writes past the last register must change nothing
                write_reg(REG_SPARE_LO, '1);
                write_reg(REG_SPARE_HI, '1);
            end
            repeat (PHASE_ITEMS) text_bytes.push_back(random_text_byte());
            wait_drained();
        end

        if (mismatch_count == 0 && expected_chars.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
